FILE: rtl/per_source_rate_limiter_assert.svh
// Assertion macros used by the checker file psrl_checker.sv.
`ifndef PER_SOURCE_RATE_LIMITER_ASSERT_SVH
`define PER_SOURCE_RATE_LIMITER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define PSRL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define PSRL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/psrl_pkg.sv
`default_nettype none

package psrl_pkg;

    localparam int PSRL_TABLE_ENTRIES = 32;
    localparam int PSRL_DATA_W        = 32;
    localparam int PSRL_SLOT_W        = 5;
    localparam int PSRL_CFG_IDX_W     = 8;

    localparam logic [PSRL_DATA_W-1:0] PSRL_CNT_MAX          = '1;
    localparam logic [PSRL_DATA_W-1:0] PSRL_RST_WINDOW_TICKS = 32'd1000;
    localparam logic [PSRL_DATA_W-1:0] PSRL_RST_GLOBAL_LIMIT = 32'd3200;
    localparam logic [PSRL_DATA_W-1:0] PSRL_RST_SOURCE_LIMIT = 32'd100;

    localparam logic [PSRL_CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 8'd0;
    localparam logic [PSRL_CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT = 8'd1;
    localparam logic [PSRL_CFG_IDX_W-1:0] CFG_SOURCE_LIMIT = 8'd2;

    typedef enum logic [1:0] {
        VERDICT_PASS   = 2'd0,
        VERDICT_GLOBAL = 2'd1,
        VERDICT_SOURCE = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLOB,
        ST_SCAN,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [PSRL_DATA_W-1:0] source_address;
        logic [PSRL_DATA_W-1:0] tick_now;
    } t_pkt;

    typedef struct packed {
        t_verdict               verdict;
        logic [PSRL_SLOT_W-1:0] slot_used;
        logic                   new_source;
        logic                   was_evicted;
        logic [PSRL_DATA_W-1:0] evicted_drop_tally;
    } t_res;

    typedef struct packed {
        logic [PSRL_DATA_W-1:0] window_ticks;
        logic [PSRL_DATA_W-1:0] global_limit;
        logic [PSRL_DATA_W-1:0] source_limit;
    } t_cfg;

    typedef struct packed {
        logic [PSRL_DATA_W-1:0] address;
        logic [PSRL_DATA_W-1:0] count;
        logic [PSRL_DATA_W-1:0] origin;
        logic [PSRL_DATA_W-1:0] seen_tick;
        logic [PSRL_DATA_W-1:0] drop_tally;
    } t_entry;

    typedef struct packed {
        logic [PSRL_DATA_W-1:0] now;
        logic [PSRL_DATA_W-1:0] origin;
        logic [PSRL_DATA_W-1:0] window;
        logic [PSRL_DATA_W-1:0] count;
        logic [PSRL_DATA_W-1:0] limit;
    } t_win_req;

    typedef struct packed {
        logic                   expired;
        logic [PSRL_DATA_W-1:0] cnt_next;
        logic                   over;
    } t_win_rsp;

    function automatic logic [PSRL_DATA_W-1:0] psrl_sat_inc(input logic [PSRL_DATA_W-1:0] v);
        return (v == PSRL_CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/psrl_stream_if.sv
`default_nettype none

interface psrl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/psrl_win_unit.sv
`default_nettype none

// Shared window unit: expiry test and saturating count against a limit.
module psrl_win_unit
    import psrl_pkg::*;
(
    input  t_win_req i_req,
    output t_win_rsp o_rsp
);

    logic [PSRL_DATA_W-1:0] elapsed;
    logic [PSRL_DATA_W-1:0] cnt_next;

    assign elapsed  = i_req.now - i_req.origin;
    assign cnt_next = psrl_sat_inc(i_req.count);

    assign o_rsp.expired  = (elapsed > i_req.window);
    assign o_rsp.cnt_next = cnt_next;
    assign o_rsp.over     = (cnt_next > i_req.limit);

endmodule

`default_nettype wire

FILE: rtl/psrl_table.sv
`default_nettype none

module psrl_table
    import psrl_pkg::*;
#(
    parameter int ENTRIES = PSRL_TABLE_ENTRIES,
    parameter int IDX_W   = $clog2(PSRL_TABLE_ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  t_entry                i_wr_data
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/psrl_ctrl.sv
`default_nettype none

module psrl_ctrl
    import psrl_pkg::*;
#(
    parameter int ENTRIES = PSRL_TABLE_ENTRIES,
    parameter int IDX_W   = $clog2(PSRL_TABLE_ENTRIES),
    parameter int CNT_W   = $clog2(PSRL_TABLE_ENTRIES + 1)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  t_cfg              i_cfg,
    psrl_stream_if.sink       i_pkt,
    psrl_stream_if.source     o_res,
    output logic              o_rd_en,
    output logic [IDX_W-1:0]  o_rd_addr,
    input  t_entry            i_rd_data,
    output logic              o_wr_en,
    output logic [IDX_W-1:0]  o_wr_addr,
    output t_entry            o_wr_data,
    output t_win_req          o_win_req,
    input  t_win_rsp          i_win_rsp
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    t_state                 r_state,     n_state;
    logic [PSRL_DATA_W-1:0] r_addr,      n_addr;
    logic [PSRL_DATA_W-1:0] r_now,       n_now;
    logic [PSRL_DATA_W-1:0] r_gcount,    n_gcount;
    logic [PSRL_DATA_W-1:0] r_gorigin,   n_gorigin;
    logic                   r_gdrop,     n_gdrop;
    logic [CNT_W-1:0]       r_used,      n_used;
    logic [CNT_W-1:0]       r_idx,       n_idx;
    logic                   r_rd_vld,    n_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx,    n_rd_idx;
    logic                   r_hit,       n_hit;
    logic [IDX_W-1:0]       r_hit_idx,   n_hit_idx;
    t_entry                 r_hit_ent,   n_hit_ent;
    logic                   r_min_vld,   n_min_vld;
    logic [IDX_W-1:0]       r_min_idx,   n_min_idx;
    logic [PSRL_DATA_W-1:0] r_min_ls,    n_min_ls;
    logic [PSRL_DATA_W-1:0] r_min_tally, n_min_tally;
    logic                   r_out_vld,   n_out_vld;
    t_res                   r_out,       n_out;

    t_entry                 upd_ent;
    logic [IDX_W-1:0]       upd_slot;

    assign i_pkt.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // The window unit serves the global check first, then the hit entry.
    always_comb begin
        o_win_req.now    = r_now;
        o_win_req.window = i_cfg.window_ticks;
        if (r_state == ST_GLOB) begin
            o_win_req.origin = r_gorigin;
            o_win_req.count  = r_gcount;
            o_win_req.limit  = i_cfg.global_limit;
        end else begin
            o_win_req.origin = r_hit_ent.origin;
            o_win_req.count  = r_hit_ent.count;
            o_win_req.limit  = i_cfg.source_limit;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_now       = r_now;
        n_gcount    = r_gcount;
        n_gorigin   = r_gorigin;
        n_gdrop     = r_gdrop;
        n_used      = r_used;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_ent   = r_hit_ent;
        n_min_vld   = r_min_vld;
        n_min_idx   = r_min_idx;
        n_min_ls    = r_min_ls;
        n_min_tally = r_min_tally;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx[IDX_W-1:0];
        o_wr_en     = 1'b0;
        upd_ent     = r_hit_ent;
        upd_slot    = r_hit_idx;

        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_pkt.valid) begin
                    n_addr  = i_pkt.data.source_address;
                    n_now   = i_pkt.data.tick_now;
                    n_state = ST_GLOB;
                end
            end
            ST_GLOB: begin
                if (i_win_rsp.expired) begin
                    n_gcount  = PSRL_DATA_W'(1);
                    n_gorigin = r_now;
                    n_gdrop   = 1'b0;
                end else begin
                    n_gcount  = i_win_rsp.cnt_next;
                    n_gdrop   = i_win_rsp.over;
                end
                n_idx     = '0;
                n_rd_vld  = 1'b0;
                n_hit     = 1'b0;
                n_min_vld = 1'b0;
                n_state   = (!i_win_rsp.expired && i_win_rsp.over) ? ST_UPD : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx < r_used) begin
                    o_rd_en  = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = ST_UPD;
                end
                // Lowest matching index wins; oldest seen tick, first on ties.
                if (r_rd_vld) begin
                    if (!r_hit && (i_rd_data.address == r_addr)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rd_idx;
                        n_hit_ent = i_rd_data;
                    end
                    if (!r_min_vld || (i_rd_data.seen_tick < r_min_ls)) begin
                        n_min_vld   = 1'b1;
                        n_min_idx   = r_rd_idx;
                        n_min_ls    = i_rd_data.seen_tick;
                        n_min_tally = i_rd_data.drop_tally;
                    end
                end
            end
            ST_UPD: begin
                // Hold until the output register is free.
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                    n_out     = '{verdict: VERDICT_PASS, slot_used: '0, new_source: 1'b0,
                                  was_evicted: 1'b0, evicted_drop_tally: '0};
                    if (r_gdrop) begin
                        n_out.verdict = VERDICT_GLOBAL;
                    end else if (r_hit) begin
                        upd_ent.seen_tick = r_now;
                        if (i_win_rsp.expired) begin
                            upd_ent.count  = PSRL_DATA_W'(1);
                            upd_ent.origin = r_now;
                        end else begin
                            upd_ent.count = i_win_rsp.cnt_next;
                            if (i_win_rsp.over) begin
                                upd_ent.drop_tally = psrl_sat_inc(r_hit_ent.drop_tally);
                                n_out.verdict      = VERDICT_SOURCE;
                            end
                        end
                        upd_slot        = r_hit_idx;
                        o_wr_en         = 1'b1;
                        n_out.slot_used = PSRL_SLOT_W'(r_hit_idx);
                    end else begin
                        upd_ent.address    = r_addr;
                        upd_ent.count      = PSRL_DATA_W'(1);
                        upd_ent.origin     = r_now;
                        upd_ent.seen_tick  = r_now;
                        upd_ent.drop_tally = '0;
                        n_out.new_source   = 1'b1;
                        if (r_used < FULL) begin
                            upd_slot = r_used[IDX_W-1:0];
                            n_used   = r_used + 1'b1;
                        end else begin
                            upd_slot                 = r_min_idx;
                            n_out.was_evicted        = 1'b1;
                            n_out.evicted_drop_tally = r_min_tally;
                        end
                        o_wr_en         = 1'b1;
                        n_out.slot_used = PSRL_SLOT_W'(upd_slot);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_wr_addr = upd_slot;
    assign o_wr_data = upd_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gcount  <= '0;
            r_gorigin <= '0;
            r_used    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gcount  <= n_gcount;
            r_gorigin <= n_gorigin;
            r_used    <= n_used;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_now       <= n_now;
        r_gdrop     <= n_gdrop;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_ent   <= n_hit_ent;
        r_min_vld   <= n_min_vld;
        r_min_idx   <= n_min_idx;
        r_min_ls    <= n_min_ls;
        r_min_tally <= n_min_tally;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/per_source_rate_limiter.sv
// Flow: an input word is accepted in idle and checked against the global limit;
// then the N table entries in use (at most TABLE_ENTRIES) are scanned, one entry
// per cycle, unless the global limit drops the word. No new word is taken until
// the result word is registered, which waits for a free output register.
// Reset (i_rst_n, synchronous, active low): counters, fill count, state,
// valid flags and config return to defaults; the entry memory is not cleared.
`default_nettype none

module per_source_rate_limiter
    import psrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = PSRL_TABLE_ENTRIES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [PSRL_CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PSRL_DATA_W-1:0]    i_cfg_data,
    psrl_stream_if.sink                    i_pkt,
    psrl_stream_if.source                  o_res
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    t_cfg             r_cfg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_win_req         win_req;
    t_win_rsp         win_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks <= PSRL_RST_WINDOW_TICKS;
            r_cfg.global_limit <= PSRL_RST_GLOBAL_LIMIT;
            r_cfg.source_limit <= PSRL_RST_SOURCE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_TICKS: r_cfg.window_ticks <= i_cfg_data;
                CFG_GLOBAL_LIMIT: r_cfg.global_limit <= i_cfg_data;
                CFG_SOURCE_LIMIT: r_cfg.source_limit <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    psrl_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_pkt     (i_pkt),
        .o_res     (o_res),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_win_req (win_req),
        .i_win_rsp (win_rsp)
    );

    psrl_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    psrl_win_unit u_win (
        .i_req (win_req),
        .o_rsp (win_rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/psrl_checker.sv
`default_nettype none
`include "per_source_rate_limiter_assert.svh"

module psrl_checker
    import psrl_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input t_res      i_out_data
);

    `PSRL_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "psrl: stalled result word changed")

    `PSRL_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "psrl: ready right after an accepted word")

    `PSRL_ASSERT_IMP(a_global_drop_clean, i_out_valid && (i_out_data.verdict == VERDICT_GLOBAL), (i_out_data.slot_used == '0) && !i_out_data.new_source && !i_out_data.was_evicted && (i_out_data.evicted_drop_tally == '0), "psrl: global drop touched the table")

    `PSRL_ASSERT_IMP(a_evict_is_new, i_out_valid && i_out_data.was_evicted, i_out_data.new_source && (i_out_data.verdict == VERDICT_PASS), "psrl: eviction without a passing new source")

    `PSRL_ASSERT_IMP(a_tally_only_on_evict, i_out_valid && !i_out_data.was_evicted, i_out_data.evicted_drop_tally == '0, "psrl: drop tally reported without eviction")

endmodule

bind per_source_rate_limiter psrl_checker u_psrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire
